@@ hw/rtl/button_press_duration_classifier_assert.svh @@
// assertion macros used by the button press classifier top level
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH

// checked at every clock edge, held off while reset is low
`define BPDC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bpdc assertion failed");

// checked at every clock edge, reset included
`define BPDC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bpdc assertion failed");

`endif

@@ hw/rtl/bpdc_pkg.sv @@
// types and constants of the button press classifier
package bpdc_pkg;

  localparam int unsigned NumButtons = 2;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned LimitBits  = 16;
  localparam int unsigned CmdBits    = 8;
  localparam int unsigned CfgAddrBits = 4;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned CmpBits    = (CountBits > LimitBits) ? CountBits : LimitBits;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [1:0] NoButton = 2'd2;

  localparam logic [CfgAddrBits-1:0] RegShortLimitB0 = 4'd0;
  localparam logic [CfgAddrBits-1:0] RegLongLimitB0  = 4'd1;
  localparam logic [CfgAddrBits-1:0] RegShortLimitB1 = 4'd2;
  localparam logic [CfgAddrBits-1:0] RegLongLimitB1  = 4'd3;
  localparam logic [CfgAddrBits-1:0] RegCmdB0Short   = 4'd4;
  localparam logic [CfgAddrBits-1:0] RegCmdB0Long    = 4'd5;
  localparam logic [CfgAddrBits-1:0] RegCmdB1Short   = 4'd6;
  localparam logic [CfgAddrBits-1:0] RegCmdB1Long    = 4'd7;

  localparam logic [LimitBits-1:0] ShortLimitReset = 16'd2;
  localparam logic [LimitBits-1:0] LongLimitReset  = 16'd10;

  typedef struct packed {
    logic [LimitBits-1:0] short_limit;
    logic [LimitBits-1:0] long_limit;
    logic [CmdBits-1:0]   cmd_short;
    logic [CmdBits-1:0]   cmd_long;
  } btn_cfg_t;

  typedef struct packed {
    logic               event_kind;
    logic [CmdBits-1:0] command_id;
    logic               button_index;
    logic               press_class;
  } result_t;

endpackage

@@ hw/rtl/button_press_duration_classifier.sv @@
// top level of the short/long button press classifier
// One beat of button levels is taken per cycle, one tick each, and a release that
// lands in a button's short or long window yields one result beat; the hold counter
// and release compare sit in front of a result register with a one-deep skid stage,
// so input is stalled only while both hold a result that the sink has not taken.
// Configuration writes land in the next cycle and reset restores limits 2 and 10
// and all commands to zero (undo).
`include "button_press_duration_classifier_assert.svh"

module button_press_duration_classifier
  import bpdc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [NumButtons-1:0]  button_levels_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   event_kind_o,
  output logic [CmdBits-1:0]     command_id_o,
  output logic                   button_index_o,
  output logic                   press_class_o,
  input  logic                   cfg_we_i,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  btn_cfg_t cfg_b0_q, cfg_b1_q;

  logic [1:0]           active_q, active_d;
  logic [CountBits-1:0] count_q, count_d;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;

  logic     in_fire;
  logic     out_fire;
  logic     held;
  logic     releasing;
  logic     hit;
  logic     res_valid;
  btn_cfg_t sel_cfg;
  result_t  result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_b0_q <= '{short_limit: ShortLimitReset, long_limit: LongLimitReset,
                    cmd_short: '0, cmd_long: '0};
      cfg_b1_q <= '{short_limit: ShortLimitReset, long_limit: LongLimitReset,
                    cmd_short: '0, cmd_long: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegShortLimitB0: cfg_b0_q.short_limit <= cfg_wdata_i[LimitBits-1:0];
        RegLongLimitB0:  cfg_b0_q.long_limit  <= cfg_wdata_i[LimitBits-1:0];
        RegShortLimitB1: cfg_b1_q.short_limit <= cfg_wdata_i[LimitBits-1:0];
        RegLongLimitB1:  cfg_b1_q.long_limit  <= cfg_wdata_i[LimitBits-1:0];
        RegCmdB0Short:   cfg_b0_q.cmd_short   <= cfg_wdata_i[CmdBits-1:0];
        RegCmdB0Long:    cfg_b0_q.cmd_long    <= cfg_wdata_i[CmdBits-1:0];
        RegCmdB1Short:   cfg_b1_q.cmd_short   <= cfg_wdata_i[CmdBits-1:0];
        RegCmdB1Long:    cfg_b1_q.cmd_long    <= cfg_wdata_i[CmdBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign releasing = (active_q != NoButton);
  assign held      = releasing && !button_levels_i[active_q[0]];
  assign sel_cfg   = active_q[0] ? cfg_b1_q : cfg_b0_q;

  bpdc_classify u_classify (
    .cfg_i    (sel_cfg),
    .count_i  (count_q),
    .button_i (active_q[0]),
    .hit_o    (hit),
    .result_o (result)
  );

  assign res_valid = in_fire && !held && releasing && hit;

  // hold tracking
  always_comb begin
    active_d = active_q;
    count_d  = count_q;
    if (in_fire) begin
      if (held) begin
        if (count_q != CountMax) begin
          count_d = count_q + 1'b1;
        end
      end else begin
        active_d = NoButton;
        priority if (!button_levels_i[0]) begin
          active_d = 2'd0;
          count_d  = CountBits'(1);
        end else if (!button_levels_i[1]) begin
          active_d = 2'd1;
          count_d  = CountBits'(1);
        end else begin
        end
      end
    end
  end

  // result register with skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_fire) begin
      out_valid_d  = skid_valid_q || res_valid;
      out_data_d   = skid_valid_q ? skid_data_q : result;
      skid_valid_d = 1'b0;
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_data_d  = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= NoButton;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      active_q     <= active_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_data_q.event_kind;
  assign command_id_o   = out_data_q.command_id;
  assign button_index_o = out_data_q.button_index;
  assign press_class_o  = out_data_q.press_class;

  `BPDC_ASSERT_ALWAYS(a_skid_implies_out, clk_i, skid_valid_q |-> out_valid_q)
  `BPDC_ASSERT(a_skid_fill_on_stall, clk_i, rst_ni,
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
  `BPDC_ASSERT(a_active_code, clk_i, rst_ni, active_q != 2'd3)
  `BPDC_ASSERT(a_count_when_active, clk_i, rst_ni,
    (active_q != NoButton) |-> (count_q != '0))
  `BPDC_ASSERT(a_undo_iff_zero, clk_i, rst_ni,
    out_valid_q |-> (event_kind_o == (command_id_o == '0)))

endmodule

@@ hw/rtl/bpdc_classify.sv @@
// release classifier: hold count against the limits of the released button
module bpdc_classify
  import bpdc_pkg::*;
(
  input  btn_cfg_t             cfg_i,
  input  logic [CountBits-1:0] count_i,
  input  logic                 button_i,
  output logic                 hit_o,
  output result_t              result_o
);

  logic [CmpBits-1:0] count_ext;
  logic [CmpBits-1:0] lo_ext;
  logic [CmpBits-1:0] hi_ext;
  logic               is_short;
  logic               is_long;
  logic [CmdBits-1:0] cmd;

  assign count_ext = CmpBits'(count_i);
  assign lo_ext    = CmpBits'(cfg_i.short_limit);
  assign hi_ext    = CmpBits'(cfg_i.long_limit);

  assign is_long  = count_ext >= hi_ext;
  assign is_short = (count_ext >= lo_ext) && !is_long;
  assign hit_o    = is_short || is_long;
  assign cmd      = is_long ? cfg_i.cmd_long : cfg_i.cmd_short;

  always_comb begin
    result_o.event_kind   = (cmd == '0);
    result_o.command_id   = cmd;
    result_o.button_index = button_i;
    result_o.press_class  = is_long;
  end

endmodule
